FILE: hw/rtl/etr_pkg.sv
package etr_pkg;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_COLLECT = 3'd1,
    ST_READY   = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_SHORT   = 3'd4,
    ST_CRC     = 3'd5,
    ST_HEADER  = 3'd6,
    ST_OVERRUN = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    REG_MASTER_ID   = 3'd0,
    REG_DEVICE      = 3'd1,
    REG_TYPE        = 3'd2,
    REG_REGISTER    = 3'd3,
    REG_TIMEOUT     = 3'd4
  } reg_idx_t;

  localparam logic [7:0]  START_BYTE  = 8'h0D;
  localparam logic [7:0]  END_BYTE    = 8'h0A;
  localparam logic [7:0]  ESC_BYTE    = 8'h5E;
  localparam logic [7:0]  ESC_OFFSET  = 8'h40;
  localparam logic [7:0]  SPACE_BYTE  = 8'h20;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam int          HDR_BYTES   = 4;
  localparam int          MIN_BYTES   = 5;
  localparam int          OVERHEAD    = 6;

  localparam logic [7:0]  MASTER_ID_RST = 8'd66;
  localparam logic [7:0]  DEVICE_RST    = 8'd15;
  localparam logic [7:0]  TYPE_RST      = 8'd8;
  localparam logic [7:0]  REGISTER_RST  = 8'd0;
  localparam logic [15:0] TIMEOUT_RST   = 16'd50;

  typedef struct packed {
    logic [7:0]  master_id;
    logic [7:0]  expected_device;
    logic [7:0]  expected_type;
    logic [7:0]  expected_register;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // result flags carried beside the status into the output register
  typedef struct packed {
    logic rd_en;
    logic space_ok;
  } rd_ctl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/etr_store.sv
module etr_store import etr_pkg::*; #(
  parameter int STORE_DEPTH = 256,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the read word while the result waits downstream
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/etr_core.sv
module etr_core import etr_pkg::*; #(
  parameter int STORE_DEPTH = 256,
  parameter int AW          = $clog2(STORE_DEPTH),
  parameter int CW          = $clog2(STORE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  op_t           op,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    read_index,
  input  cfg_t          cfg,
  output status_t       status_nxt,
  output logic [7:0]    plen_nxt,
  output rd_ctl_t       rd_ctl,
  output logic          st_we,
  output logic [AW-1:0] st_waddr,
  output logic [7:0]    st_wdata,
  output logic [AW-1:0] st_raddr
);

  localparam int LW = (CW > 8) ? CW : 8;

  status_t       status_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          esc_r, esc_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [15:0]   ticks_r, ticks_nxt;
  logic [7:0]    hdr_r [HDR_BYTES];

  logic [7:0]    byte_val;
  logic          store_en;
  logic          hdr_ok;
  logic [LW-1:0] diff;

  assign byte_val = esc_r ? (rx_byte - ESC_OFFSET) : rx_byte;
  assign hdr_ok   = (hdr_r[0] == cfg.master_id) && (hdr_r[1] == cfg.expected_device) &&
                    (hdr_r[2] == cfg.expected_type) && (hdr_r[3] == cfg.expected_register);

  // next state
  always_comb begin
    status_nxt = status_r;
    count_nxt  = count_r;
    esc_nxt    = esc_r;
    crc_nxt    = crc_r;
    ticks_nxt  = ticks_r;
    store_en   = 1'b0;
    case (op)
      OP_ARM: begin
        status_nxt = ST_HUNT;
        ticks_nxt  = cfg.timeout_ticks;
      end
      OP_BYTE: begin
        if (status_r == ST_HUNT) begin
          if (rx_byte == START_BYTE) begin
            count_nxt  = '0;
            esc_nxt    = 1'b0;
            crc_nxt    = '0;
            status_nxt = ST_COLLECT;
          end
        end else if (status_r == ST_COLLECT) begin
          if (rx_byte == END_BYTE) begin
            if (count_r < CW'(MIN_BYTES)) begin
              status_nxt = ST_SHORT;
            end else if (crc_r != '0) begin
              status_nxt = ST_CRC;
            end else if (hdr_ok) begin
              status_nxt = ST_READY;
            end else begin
              status_nxt = ST_HEADER;
            end
          end else if (rx_byte == ESC_BYTE) begin
            esc_nxt = 1'b1;
          end else begin
            esc_nxt = 1'b0;
            if (count_r >= CW'(STORE_DEPTH)) begin
              status_nxt = ST_OVERRUN;
            end else begin
              store_en  = 1'b1;
              crc_nxt   = crc16_byte(crc_r, byte_val);
              count_nxt = count_r + CW'(1);
            end
          end
        end
      end
      OP_TICK: begin
        if (status_r inside {ST_HUNT, ST_COLLECT}) begin
          if (ticks_r != '0) begin
            ticks_nxt = ticks_r - 16'd1;
          end else begin
            status_nxt = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    diff = LW'(count_nxt) - LW'(OVERHEAD);
    if (status_nxt != ST_READY || count_nxt < CW'(OVERHEAD)) begin
      plen_nxt = '0;
    end else if (diff > LW'(255)) begin
      plen_nxt = 8'hFF;
    end else begin
      plen_nxt = diff[7:0];
    end
    rd_ctl.rd_en    = (op == OP_READ) && (read_index < plen_nxt);
    rd_ctl.space_ok = ({1'b0, read_index} + 9'd1) < {1'b0, plen_nxt};
    st_we    = adv && store_en;
    st_waddr = count_r[AW-1:0];
    st_wdata = byte_val;
    st_raddr = AW'(9'(HDR_BYTES) + {1'b0, read_index});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_HUNT;
      count_r  <= '0;
      esc_r    <= 1'b0;
      crc_r    <= '0;
      ticks_r  <= TIMEOUT_RST;
    end else if (adv) begin
      status_r <= status_nxt;
      count_r  <= count_nxt;
      esc_r    <= esc_nxt;
      crc_r    <= crc_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

  // shadow the header bytes so the check needs no store read
  always_ff @(posedge clk) begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      if (adv && store_en && count_r == CW'(k)) begin
        hdr_r[k] <= byte_val;
      end
    end
  end

endmodule

FILE: hw/rtl/escaped_telegram_receiver_crc16_top.sv
// Pipeline: the accepting edge loads the input register; the output register and
// the store read register load when the beat advances, which out_stall can hold
// off while an earlier result waits.
// Throughput: one beat per cycle while out_stall is low; while a result waits, one more beat is taken.
// Reset (rst_n low, synchronous): hunting, timeout 50, registers at defaults.
// The telegram store needs no clearing pass; only bytes of the current
// telegram are ever read.
module escaped_telegram_receiver_crc16_top import etr_pkg::*; #(
  parameter int STORE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_payload_length,
  output logic [7:0]  out_read_byte,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_DEPTH);

  cfg_t          cfg_r;
  logic          s1_valid_r;
  op_t           s1_op_r;
  logic [7:0]    s1_byte_r;
  logic [7:0]    s1_idx_r;
  logic          out_valid_r;
  status_t       out_status_r;
  logic [7:0]    out_plen_r;
  rd_ctl_t       out_rd_r;

  logic          in_acc;
  logic          adv;
  status_t       status_nxt;
  logic [7:0]    plen_nxt;
  rd_ctl_t       rd_ctl;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_wdata;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.master_id         <= MASTER_ID_RST;
      cfg_r.expected_device   <= DEVICE_RST;
      cfg_r.expected_type     <= TYPE_RST;
      cfg_r.expected_register <= REGISTER_RST;
      cfg_r.timeout_ticks     <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASTER_ID: cfg_r.master_id         <= cfg_wdata[7:0];
        REG_DEVICE:    cfg_r.expected_device   <= cfg_wdata[7:0];
        REG_TYPE:      cfg_r.expected_type     <= cfg_wdata[7:0];
        REG_REGISTER:  cfg_r.expected_register <= cfg_wdata[7:0];
        REG_TIMEOUT:   cfg_r.timeout_ticks     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_acc || (s1_valid_r && !adv);
      out_valid_r <= adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_t'(in_op);
      s1_byte_r <= in_rx_byte;
      s1_idx_r  <= in_read_index;
    end
    if (adv) begin
      out_status_r <= status_nxt;
      out_plen_r   <= plen_nxt;
      out_rd_r     <= rd_ctl;
    end
  end

  etr_core #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .op         (s1_op_r),
    .rx_byte    (s1_byte_r),
    .read_index (s1_idx_r),
    .cfg        (cfg_r),
    .status_nxt (status_nxt),
    .plen_nxt   (plen_nxt),
    .rd_ctl     (rd_ctl),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_raddr   (st_raddr)
  );

  etr_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (adv),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // output zero unless a read is enabled; show a zero byte as a space unless it is the last payload byte
  always_comb begin
    if (!out_rd_r.rd_en) begin
      out_read_byte = '0;
    end else if (st_rdata == 8'h00 && out_rd_r.space_ok) begin
      out_read_byte = SPACE_BYTE;
    end else begin
      out_read_byte = st_rdata;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_length = out_plen_r;

endmodule
